/* rtl/mls_pkg.sv */
package mls_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int CFG_WIDTH      = 32;
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int DUR_WIDTH      = 32;

  // register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_ON_TIME      = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_FOLLOW       = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_BLINK_HALF   = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_BLINK_DUR    = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_MIN_ON       = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_MIN_OFF      = 3'd5;

  // request modes
  localparam logic [1:0] MODE_TICK      = 2'd0;
  localparam logic [1:0] MODE_TRIGGER   = 2'd1;
  localparam logic [1:0] MODE_FORCE_ON  = 2'd2;
  localparam logic [1:0] MODE_FORCE_OFF = 2'd3;

  // phase codes as seen on the result
  localparam logic [2:0] PHASE_IDLE  = 3'd0;
  localparam logic [2:0] PHASE_FON   = 3'd1;
  localparam logic [2:0] PHASE_FOFF  = 3'd2;
  localparam logic [2:0] PHASE_TRIG  = 3'd3;
  localparam logic [2:0] PHASE_BLINK = 3'd4;

  localparam logic [CFG_WIDTH-1:0] ON_TIME_RST    = 32'd30000;
  localparam logic [CFG_WIDTH-1:0] BLINK_HALF_RST = 32'd250;
  localparam logic [CFG_WIDTH-1:0] BLINK_DUR_RST  = 32'd2000;
  localparam logic [CFG_WIDTH-1:0] MIN_ON_RST     = 32'd1000;
  localparam logic [CFG_WIDTH-1:0] MIN_OFF_RST    = 32'd1000;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_FON   = 5'b00010,
    PH_FOFF  = 5'b00100,
    PH_TRIG  = 5'b01000,
    PH_BLINK = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [1:0]           mode;
    logic [DUR_WIDTH-1:0] duration_ms;
  } mls_in_t;

  typedef struct packed {
    logic       lamp;
    logic [2:0] phase;
    logic       triggered_on;
  } mls_out_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] on_time_ms;
    logic                 follow_mode;
    logic [CFG_WIDTH-1:0] blink_half_period_ms;
    logic [CFG_WIDTH-1:0] blink_duration_ms;
    logic [CFG_WIDTH-1:0] min_on_ms;
    logic [CFG_WIDTH-1:0] min_off_ms;
  } mls_cfg_t;

  function automatic logic [CFG_WIDTH-1:0] at_least(input logic [CFG_WIDTH-1:0] v,
                                                    input logic [CFG_WIDTH-1:0] lo);
    return (v < lo) ? lo : v;
  endfunction

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    case (ph)
      PH_IDLE:  code = PHASE_IDLE;
      PH_FON:   code = PHASE_FON;
      PH_FOFF:  code = PHASE_FOFF;
      PH_TRIG:  code = PHASE_TRIG;
      PH_BLINK: code = PHASE_BLINK;
      default:  code = PHASE_IDLE;
    endcase
    return code;
  endfunction

endpackage

/* rtl/motion_light_sequencer.sv */
// Motion light sequencer: drives one lamp from a stream of requests (1 ms
// ticks, motion triggers, forced on/off with a duration) and returns one
// result per request with the lamp level and phase after it. Throughput is
// one request per clock while out_stall is low, via one input register and
// one result register, state update in between. Configuration writes
// take effect at once and belong only in idle periods. Timers are
// TIME_WIDTH bits; longer durations clamp to the largest timer value.
module motion_light_sequencer
  import mls_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  mls_in_t                  in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output mls_out_t                 out_data,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]     cfg_data
);

  mls_cfg_t cfg_r;
  logic     req_valid_r;
  mls_in_t  req_r;
  logic     out_valid_r;
  mls_out_t out_data_r;
  mls_out_t res;
  logic     advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_time_ms           <= ON_TIME_RST;
      cfg_r.follow_mode          <= 1'b0;
      cfg_r.blink_half_period_ms <= BLINK_HALF_RST;
      cfg_r.blink_duration_ms    <= BLINK_DUR_RST;
      cfg_r.min_on_ms            <= MIN_ON_RST;
      cfg_r.min_off_ms           <= MIN_OFF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ON_TIME:    cfg_r.on_time_ms           <= cfg_data;
        CFG_FOLLOW:     cfg_r.follow_mode          <= cfg_data[0];
        CFG_BLINK_HALF: cfg_r.blink_half_period_ms <= cfg_data;
        CFG_BLINK_DUR:  cfg_r.blink_duration_ms    <= cfg_data;
        CFG_MIN_ON:     cfg_r.min_on_ms            <= cfg_data;
        CFG_MIN_OFF:    cfg_r.min_off_ms           <= cfg_data;
        default: ;
      endcase
    end
  end

  // request moves into the result register when that slot is free or drains
  assign advance  = req_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = req_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) req_valid_r <= in_valid;
      if (advance) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) req_r <= in_data;
    if (advance) out_data_r <= res;
  end

  mls_core #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (req_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/mls_core.sv */
module mls_core
  import mls_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step_en,
  input  mls_in_t  item,
  input  mls_cfg_t cfg,
  output mls_out_t res
);

  localparam int WW = (TIME_WIDTH > CFG_WIDTH) ? TIME_WIDTH : CFG_WIDTH;
  localparam logic [WW-1:0]         TMAX = WW'({TIME_WIDTH{1'b1}});
  localparam logic [TIME_WIDTH-1:0] ONE  = TIME_WIDTH'(1);

  // 32-bit durations clamp to the largest timer value
  function automatic logic [TIME_WIDTH-1:0] sat_time(input logic [CFG_WIDTH-1:0] v);
    logic [WW-1:0] ext;
    ext = WW'(v);
    if (ext > TMAX) ext = TMAX;
    return TIME_WIDTH'(ext);
  endfunction

  phase_t                phase_r, phase_nxt;
  logic [TIME_WIDTH-1:0] phase_cnt_r, phase_cnt_nxt;
  logic                  phase_run_r, phase_run_nxt;
  logic [TIME_WIDTH-1:0] blink_cnt_r, blink_cnt_nxt;
  logic                  blink_run_r, blink_run_nxt;
  logic                  toggle_r, toggle_nxt;
  logic                  lamp_r, lamp_nxt;

  logic [TIME_WIDTH-1:0] on_ld, half_ld, bdur_ld, fon_ld, foff_ld;

  assign on_ld   = sat_time(at_least(cfg.on_time_ms, cfg.min_on_ms));
  assign half_ld = sat_time(cfg.blink_half_period_ms);
  assign bdur_ld = sat_time(cfg.blink_duration_ms);
  assign fon_ld  = sat_time(at_least(item.duration_ms, cfg.min_on_ms));
  assign foff_ld = sat_time(at_least(item.duration_ms, cfg.min_off_ms));

  always_comb begin
    phase_nxt     = phase_r;
    phase_cnt_nxt = phase_cnt_r;
    phase_run_nxt = phase_run_r;
    blink_cnt_nxt = blink_cnt_r;
    blink_run_nxt = blink_run_r;
    toggle_nxt    = toggle_r;
    lamp_nxt      = lamp_r;
    case (item.mode)
      MODE_TICK: begin
        // blink timer first; a phase end below overrides a toggle
        if (blink_run_r) begin
          blink_cnt_nxt = blink_cnt_r - ONE;
          if (blink_cnt_r == ONE) begin
            toggle_nxt    = ~toggle_r;
            lamp_nxt      = ~toggle_r;
            blink_cnt_nxt = half_ld;
            blink_run_nxt = (half_ld != '0);
          end
        end
        if (phase_run_r) begin
          phase_cnt_nxt = phase_cnt_r - ONE;
          if (phase_cnt_r == ONE) begin
            phase_run_nxt = 1'b0;
            case (phase_r)
              PH_BLINK: begin
                blink_run_nxt = 1'b0;
                blink_cnt_nxt = '0;
                lamp_nxt      = 1'b1;
                phase_nxt     = PH_TRIG;
                phase_cnt_nxt = on_ld;
                phase_run_nxt = (on_ld != '0);
              end
              PH_FON, PH_TRIG: begin
                lamp_nxt      = 1'b0;
                phase_nxt     = PH_IDLE;
                phase_cnt_nxt = '0;
              end
              default: begin
                phase_nxt     = PH_IDLE;
                phase_cnt_nxt = '0;
              end
            endcase
          end
        end
      end
      MODE_TRIGGER: begin
        if (phase_r != PH_FOFF) begin
          if (!cfg.follow_mode && phase_r == PH_TRIG) begin
            lamp_nxt      = 1'b1;
            phase_cnt_nxt = on_ld;
            phase_run_nxt = (on_ld != '0);
          end else begin
            blink_cnt_nxt = half_ld;
            blink_run_nxt = (half_ld != '0);
            phase_nxt     = PH_BLINK;
            phase_cnt_nxt = bdur_ld;
            phase_run_nxt = (bdur_ld != '0);
          end
        end
      end
      MODE_FORCE_ON: begin
        blink_run_nxt = 1'b0;
        blink_cnt_nxt = '0;
        lamp_nxt      = 1'b1;
        phase_nxt     = PH_FON;
        phase_cnt_nxt = fon_ld;
        phase_run_nxt = (fon_ld != '0);
      end
      default: begin
        blink_run_nxt = 1'b0;
        blink_cnt_nxt = '0;
        lamp_nxt      = 1'b0;
        phase_nxt     = PH_FOFF;
        phase_cnt_nxt = foff_ld;
        phase_run_nxt = (foff_ld != '0);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      phase_cnt_r <= '0;
      phase_run_r <= 1'b0;
      blink_cnt_r <= '0;
      blink_run_r <= 1'b0;
      toggle_r    <= 1'b0;
      lamp_r      <= 1'b0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      phase_cnt_r <= phase_cnt_nxt;
      phase_run_r <= phase_run_nxt;
      blink_cnt_r <= blink_cnt_nxt;
      blink_run_r <= blink_run_nxt;
      toggle_r    <= toggle_nxt;
      lamp_r      <= lamp_nxt;
    end
  end

  assign res.lamp         = lamp_nxt;
  assign res.phase        = phase_code(phase_nxt);
  assign res.triggered_on = (phase_nxt == PH_TRIG);

endmodule
